/* rtl/bnnt_pkg.sv */
// bnnt_pkg: types and fixed constants of the banded nearest-neighbor tracker.
// Standalone package; used by banded_nearest_neighbor_tracker_unit.
package bnnt_pkg;

	localparam int unsigned POS_W   = 16;
	localparam int unsigned DIST_W  = 16;
	localparam int unsigned SEP_W   = 7;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic FUNC_ENTRY  = 1'b0;
	localparam logic FUNC_FINISH = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SEP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEP = 1'b1;

	localparam logic [SEP_W-1:0] MIN_SEP_RESET = 7'd1;
	localparam logic [SEP_W-1:0] MAX_SEP_RESET = 7'd127;

	localparam logic [POS_W-1:0]  POS_NONE  = 16'hFFFF;
	localparam logic [DIST_W-1:0] DIST_NONE = 16'hFFFF;

	typedef struct packed {
		logic [POS_W-1:0]  pos;
		logic [DIST_W-1:0] dcode;
	} ring_entry_t;

	localparam ring_entry_t ENTRY_NONE = '{pos: POS_NONE, dcode: DIST_NONE};

endpackage

/* rtl/banded_nearest_neighbor_tracker_unit.sv */
// banded_nearest_neighbor_tracker_unit: top level; forward and backward ring memories
// with read-modify-write, forwarding and a result register. Depends on bnnt_pkg.
//
// channel  direction  handshake             payload
// in       sink       in_valid / in_stall    func, row_pos, col_pos, distance_code
// out      source     out_valid / out_stall  position, fwd_*, bwd_*, near_*, far_*, side_code
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One transaction per cycle while in is not stalled; each ring memory takes one read and one write a cycle.
// A finish result is loaded into the result register when its accepted transaction fires
// out of stage one.
// After reset a clearing pass writes empty entries to all slots of both rings; in is stalled.
// in stalls while a finish sits in stage one and the result register is held by out_stall.
// cfg is always ready.
module banded_nearest_neighbor_tracker_unit #(
	parameter int unsigned RING_DEPTH = 128
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              func,
	input  logic [bnnt_pkg::POS_W-1:0]        row_pos,
	input  logic [bnnt_pkg::POS_W-1:0]        col_pos,
	input  logic [bnnt_pkg::DIST_W-1:0]       distance_code,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [bnnt_pkg::POS_W-1:0]        position,
	output logic [bnnt_pkg::POS_W-1:0]        fwd_neighbor,
	output logic [bnnt_pkg::DIST_W-1:0]       fwd_distance,
	output logic [bnnt_pkg::POS_W-1:0]        bwd_neighbor,
	output logic [bnnt_pkg::DIST_W-1:0]       bwd_distance,
	output logic [bnnt_pkg::POS_W-1:0]        near_neighbor,
	output logic [bnnt_pkg::DIST_W-1:0]       near_distance,
	output logic [bnnt_pkg::POS_W-1:0]        far_neighbor,
	output logic [bnnt_pkg::DIST_W-1:0]       far_distance,
	output logic                              side_code,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bnnt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bnnt_pkg::SEP_W-1:0]        cfg_data
);

	localparam int unsigned AW = $clog2(RING_DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);

	function automatic logic [255:0][AW-1:0] build_tab(input int unsigned scale);
		logic [255:0][AW-1:0] tab;
		for (int k = 0; k < 256; k++) begin
			tab[k] = AW'((k * scale) % RING_DEPTH);
		end
		return tab;
	endfunction

	localparam logic [255:0][AW-1:0] HI_TAB = build_tab(256);
	localparam logic [255:0][AW-1:0] LO_TAB = build_tab(1);

	function automatic logic [AW-1:0] slot_of(input logic [bnnt_pkg::POS_W-1:0] pos);
		logic [AW:0] sum;
		sum = {1'b0, HI_TAB[pos[15:8]]} + {1'b0, LO_TAB[pos[7:0]]};
		if (sum >= (AW+1)'(RING_DEPTH)) begin
			sum = sum - (AW+1)'(RING_DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	logic [bnnt_pkg::SEP_W-1:0] min_sep_q;
	logic [bnnt_pkg::SEP_W-1:0] max_sep_q;

	logic          clr_q;
	logic [AW-1:0] clr_cnt_q;

	logic                          v_s1;
	logic                          fin_s1;
	logic [bnnt_pkg::POS_W-1:0]    row_s1;
	logic [bnnt_pkg::POS_W-1:0]    col_s1;
	logic [bnnt_pkg::DIST_W-1:0]   dist_s1;
	logic [AW-1:0]                 fslot_s1;
	logic [AW-1:0]                 bslot_s1;
	bnnt_pkg::ring_entry_t         fwd_rd_s1;
	bnnt_pkg::ring_entry_t         bwd_rd_s1;

	logic                          ffw_v_q;
	logic [AW-1:0]                 ffw_a_q;
	bnnt_pkg::ring_entry_t         ffw_d_q;
	logic                          bfw_v_q;
	logic [AW-1:0]                 bfw_a_q;
	bnnt_pkg::ring_entry_t         bfw_d_q;

	logic                          out_v_q;

	bnnt_pkg::ring_entry_t fwd_mem [RING_DEPTH];
	bnnt_pkg::ring_entry_t bwd_mem [RING_DEPTH];

	logic                    accept;
	logic                    fire_s1;
	logic                    keep;
	logic [bnnt_pkg::POS_W:0] sep;
	logic [AW-1:0]           row_slot;
	logic [AW-1:0]           col_slot;
	logic [AW-1:0]           bwd_ra;
	bnnt_pkg::ring_entry_t   fwd_cur;
	bnnt_pkg::ring_entry_t   bwd_cur;
	bnnt_pkg::ring_entry_t   fwd_new;
	bnnt_pkg::ring_entry_t   bwd_new;
	logic                    mem_we;
	logic [AW-1:0]           fwd_wa;
	logic [AW-1:0]           bwd_wa;
	bnnt_pkg::ring_entry_t   fwd_wd;
	bnnt_pkg::ring_entry_t   bwd_wd;
	logic                    fwd_near;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_sep_q <= bnnt_pkg::MIN_SEP_RESET;
			max_sep_q <= bnnt_pkg::MAX_SEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bnnt_pkg::CFG_MIN_SEP: min_sep_q <= cfg_data;
				bnnt_pkg::CFG_MAX_SEP: max_sep_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input decode and slot mapping
	always_comb begin
		sep      = {1'b0, col_pos} - {1'b0, row_pos};
		row_slot = slot_of(row_pos);
		col_slot = slot_of(col_pos);
		bwd_ra   = (func == bnnt_pkg::FUNC_FINISH) ? row_slot : col_slot;
		keep     = (func == bnnt_pkg::FUNC_FINISH) ||
		           (!sep[bnnt_pkg::POS_W] &&
		            sep[bnnt_pkg::POS_W-1:0] >= {9'd0, min_sep_q} &&
		            sep[bnnt_pkg::POS_W-1:0] <= {9'd0, max_sep_q});
	end

	assign fire_s1  = v_s1 && !(fin_s1 && out_v_q && out_stall);
	assign in_stall = clr_q || (v_s1 && !fire_s1);
	assign accept   = in_valid && !in_stall;

	// stage one: merge last write, compare (or clear on finish), write back
	always_comb begin
		fwd_cur = (ffw_v_q && ffw_a_q == fslot_s1) ? ffw_d_q : fwd_rd_s1;
		bwd_cur = (bfw_v_q && bfw_a_q == bslot_s1) ? bfw_d_q : bwd_rd_s1;
		if (fin_s1) begin
			fwd_new = bnnt_pkg::ENTRY_NONE;
			bwd_new = bnnt_pkg::ENTRY_NONE;
		end else begin
			fwd_new = (dist_s1 < fwd_cur.dcode) ?
			          bnnt_pkg::ring_entry_t'{pos: col_s1, dcode: dist_s1} : fwd_cur;
			bwd_new = (dist_s1 < bwd_cur.dcode) ?
			          bnnt_pkg::ring_entry_t'{pos: row_s1, dcode: dist_s1} : bwd_cur;
		end
		fwd_near = (fwd_cur.dcode <= bwd_cur.dcode);
		mem_we   = clr_q || fire_s1;
		fwd_wa   = clr_q ? clr_cnt_q : fslot_s1;
		bwd_wa   = clr_q ? clr_cnt_q : bslot_s1;
		fwd_wd   = clr_q ? bnnt_pkg::ENTRY_NONE : fwd_new;
		bwd_wd   = clr_q ? bnnt_pkg::ENTRY_NONE : bwd_new;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			fwd_mem[fwd_wa] <= fwd_wd;
			bwd_mem[bwd_wa] <= bwd_wd;
		end
		if (accept) begin
			fwd_rd_s1 <= fwd_mem[row_slot];
			bwd_rd_s1 <= bwd_mem[bwd_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
			if (clr_cnt_q == LAST_SLOT) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			ffw_v_q <= 1'b0;
			bfw_v_q <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= keep;
			end else if (fire_s1) begin
				v_s1 <= 1'b0;
			end
			if (accept || fire_s1) begin
				ffw_v_q <= accept && fire_s1;
				bfw_v_q <= accept && fire_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fin_s1   <= func;
			row_s1   <= row_pos;
			col_s1   <= col_pos;
			dist_s1  <= distance_code;
			fslot_s1 <= row_slot;
			bslot_s1 <= bwd_ra;
		end
		if (accept || fire_s1) begin
			ffw_a_q <= fslot_s1;
			ffw_d_q <= fwd_new;
			bfw_a_q <= bslot_s1;
			bfw_d_q <= bwd_new;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (fire_s1 && fin_s1) begin
			out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && fin_s1) begin
			position      <= row_s1;
			fwd_neighbor  <= fwd_cur.pos;
			fwd_distance  <= fwd_cur.dcode;
			bwd_neighbor  <= bwd_cur.pos;
			bwd_distance  <= bwd_cur.dcode;
			near_neighbor <= fwd_near ? fwd_cur.pos : bwd_cur.pos;
			near_distance <= fwd_near ? fwd_cur.dcode : bwd_cur.dcode;
			far_neighbor  <= fwd_near ? bwd_cur.pos : fwd_cur.pos;
			far_distance  <= fwd_near ? bwd_cur.dcode : fwd_cur.dcode;
			side_code     <= !fwd_near;
		end
	end

	assign out_valid = out_v_q;

	a_clear_full_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_q) |-> $past(clr_cnt_q) == LAST_SLOT)
		else $error("clearing pass ended early");

	a_finish_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && fin_s1 |=> out_valid && position == $past(row_s1))
		else $error("finish transaction did not load the result register");

	a_entry_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && !fin_s1 |=> !$rose(out_v_q))
		else $error("distance entry produced a result");

	a_finish_enters_stage: assert property (@(posedge clk) disable iff (!arst_n)
		accept && func == bnnt_pkg::FUNC_FINISH |=> v_s1 && fin_s1)
		else $error("finish transaction lost before stage one");

	a_forward_slot_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && fin_s1 && accept |=> ffw_v_q && ffw_d_q == bnnt_pkg::ENTRY_NONE)
		else $error("finish clear not forwarded to next transaction");

endmodule
